/* design/rbd_pkg.sv */
// Shared types for the restoring binary divider.
// No dependencies; imported by the step stage and the top level.
package rbd_pkg;

    typedef struct packed {
        logic valid;
        logic ready;
    } t_stage_stat;

endpackage

/* design/rbd_stage.sv */
// One restoring division step held in its own pipeline register.
// Depends on rbd_pkg for the stage status type.
module rbd_stage #(
    parameter int WIDTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [WIDTH-1:0]          i_rem,
    input  logic [WIDTH-1:0]          i_nq,
    input  logic [WIDTH-1:0]          i_den,
    input  logic                      i_stall,
    output rbd_pkg::t_stage_stat      o_stat,
    output logic [WIDTH-1:0]          o_rem,
    output logic [WIDTH-1:0]          o_nq,
    output logic [WIDTH-1:0]          o_den
);
    import rbd_pkg::*;

    logic             r_valid;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_nq;
    logic [WIDTH-1:0] r_den;

    logic             n_valid;
    logic [WIDTH-1:0] n_rem;
    logic [WIDTH-1:0] n_nq;
    logic             ready;
    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;
    logic             take;

    // The partial remainder is WIDTH+1 bits wide once shifted.
    assign trial = {i_rem, i_nq[WIDTH-1]};
    assign diff  = trial - {1'b0, i_den};
    assign take  = ~diff[WIDTH];

    assign ready   = ~r_valid | ~i_stall;
    assign n_valid = ready ? i_valid : r_valid;
    assign n_rem   = take ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
    assign n_nq    = {i_nq[WIDTH-2:0], take};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready && i_valid) begin
            r_rem <= n_rem;
            r_nq  <= n_nq;
            r_den <= i_den;
        end
    end

    assign o_stat.valid = r_valid;
    assign o_stat.ready = ready;
    assign o_rem        = r_rem;
    assign o_nq         = r_nq;
    assign o_den        = r_den;

endmodule

/* design/restoring_binary_divider.sv */
// Unsigned restoring divider, one pipeline stage per quotient bit.
// An accepted transaction is registered in each step stage in turn before its result appears.
// Throughput is one transaction per cycle, set by the chain of step stages, unless i_stall holds them.
// A stalled stage holds while empty stages ahead of it keep filling.
// Synchronous active-low reset empties the pipeline; payloads are not cleared.
// Depends on rbd_pkg and rbd_stage.
module restoring_binary_divider #(
    parameter int WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [WIDTH-1:0] o_quotient,
    output logic [WIDTH-1:0] o_remainder
);
    import rbd_pkg::*;

    t_stage_stat      stat  [WIDTH];
    logic [WIDTH-1:0] rem   [WIDTH];
    logic [WIDTH-1:0] nq    [WIDTH];
    logic [WIDTH-1:0] den   [WIDTH];

    genvar k;
    generate
        for (k = 0; k < WIDTH; k++) begin : g_step
            logic             up_valid;
            logic [WIDTH-1:0] up_rem;
            logic [WIDTH-1:0] up_nq;
            logic [WIDTH-1:0] up_den;
            logic             dn_stall;

            if (k == 0) begin : g_first
                assign up_valid = i_valid;
                assign up_rem   = '0;
                assign up_nq    = i_dividend;
                assign up_den   = i_divisor;
            end else begin : g_next
                assign up_valid = stat[k-1].valid;
                assign up_rem   = rem[k-1];
                assign up_nq    = nq[k-1];
                assign up_den   = den[k-1];
            end

            if (k == WIDTH - 1) begin : g_last
                assign dn_stall = i_stall;
            end else begin : g_mid
                assign dn_stall = ~stat[k+1].ready;
            end

            rbd_stage #(
                .WIDTH (WIDTH)
            ) u_stage (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (up_valid),
                .i_rem   (up_rem),
                .i_nq    (up_nq),
                .i_den   (up_den),
                .i_stall (dn_stall),
                .o_stat  (stat[k]),
                .o_rem   (rem[k]),
                .o_nq    (nq[k]),
                .o_den   (den[k])
            );
        end
    endgenerate

    assign o_stall     = ~stat[0].ready;
    assign o_valid     = stat[WIDTH-1].valid;
    assign o_quotient  = nq[WIDTH-1];
    assign o_remainder = rem[WIDTH-1];

endmodule
